@@ rtl/u8afn_pkg.sv @@
`default_nettype none
package u8afn_pkg;

   localparam logic [7:0] LEAD_BYTE  = 8'hC3;
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] NO_FOLD    = 8'h00;
   localparam int unsigned QUEUE_DEPTH = 3;

   typedef logic [1:0] count_type;

   // outcome of normalizing one byte against the separator state
   typedef struct packed {
      logic       emit;
      logic       space;
      logic [7:0] data;
      logic       after_sep;
      logic       space_owed;
   } norm_type;

   // plain lower-case letter for the byte after a 0xC3 lead, NO_FOLD if none
   function automatic logic [7:0] fold_second(input logic [7:0] b);
      logic [7:0] k;
      k = b & 8'hDF;
      if (b < 8'h80 || b > 8'hBF) return NO_FOLD;
      if (k <= 8'h85) return "a";
      if (k >= 8'h88 && k <= 8'h8B) return "e";
      if (k >= 8'h8C && k <= 8'h8F) return "i";
      if (k == 8'h91) return "n";
      if (k >= 8'h92 && k <= 8'h96) return "o";
      if (k >= 8'h99 && k <= 8'h9C) return "u";
      return NO_FOLD;
   endfunction

   function automatic norm_type norm_byte(input logic [7:0] x, input logic after_sep,
                                          input logic space_owed);
      norm_type r;
      logic [7:0] lc;
      lc = (x >= "A" && x <= "Z") ? x + 8'h20 : x;
      r.emit       = 1'b0;
      r.space      = 1'b0;
      r.data       = lc;
      r.after_sep  = after_sep;
      r.space_owed = space_owed;
      if (x >= 8'h80 || (lc >= "a" && lc <= "z") || (lc >= "0" && lc <= "9")) begin
         r.emit       = 1'b1;
         r.space      = space_owed;
         r.after_sep  = 1'b0;
         r.space_owed = 1'b0;
      end else if (!after_sep) begin
         r.after_sep  = 1'b1;
         r.space_owed = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/utf8_accent_fold_normalizer_core.sv @@
// UTF-8 accent-folding query normalizer.
// Input channel req_*: one query byte per beat in req_tdata, req_tlast marks
// the last byte of the string. Result channel rsp_*: one normalized byte per
// beat; rsp_tuser is 1 when rsp_tdata carries a byte and 0 for a bare end
// marker, rsp_tlast marks the last result of the normalized string.
// Each accepted byte is worked out in the cycle it is accepted and its zero
// to three results are loaded into a three-entry result register; the first
// result appears on rsp_* in the cycle after the input beat.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver is ready; a byte that gives two or three results (held
// 0xC3 released raw, owed space) holds the input while the result register
// drains, one result per cycle while the receiver is ready.
// A new byte is taken when the result register is empty or its last entry
// leaves in the same cycle, so a stalled receiver stops the input after at
// most one buffered byte's results.
// Reset (synchronous, active high) empties the result register and returns
// the separator and lead-byte state to string start; no clearing pass.
`default_nettype none
module utf8_accent_fold_normalizer_core
   import u8afn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // string_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tuser,   // byte_present
   output logic            rsp_tlast    // final_result
);

   logic       lead_held_ff, lead_held_in;
   logic       after_sep_ff, after_sep_in;
   logic       space_owed_ff, space_owed_in;
   count_type  count_ff, count_in;
   logic [7:0] q_byte_ff [QUEUE_DEPTH];
   logic [7:0] q_byte_in [QUEUE_DEPTH];
   logic       q_pres_ff [QUEUE_DEPTH];
   logic       q_pres_in [QUEUE_DEPTH];
   logic       q_fin_ff  [QUEUE_DEPTH];
   logic       q_fin_in  [QUEUE_DEPTH];

   logic       accept, pop;
   logic [7:0] new_byte [QUEUE_DEPTH];
   logic       new_pres [QUEUE_DEPTH];
   logic       new_fin  [QUEUE_DEPTH];
   count_type  new_count;
   logic       step_lead, step_sep, step_owed;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = q_byte_ff[0];
   assign rsp_tuser  = q_pres_ff[0];
   assign rsp_tlast  = q_fin_ff[0];
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // results and next state for the byte on the input
   always_comb begin
      logic [7:0] f;
      logic [7:0] x1;
      logic       use1, use2, fresh, sa, so;
      norm_type   r1, r2;
      count_type  n;
      f     = fold_second(req_tdata);
      use1  = lead_held_ff;
      fresh = !lead_held_ff || (f == NO_FOLD);
      x1    = (f != NO_FOLD) ? f : LEAD_BYTE;
      sa    = after_sep_ff;
      so    = space_owed_ff;
      r1    = norm_byte(x1, sa, so);
      if (use1) begin
         sa = r1.after_sep;
         so = r1.space_owed;
      end
      step_lead = fresh && req_tdata == LEAD_BYTE && !req_tlast;
      use2      = fresh && !step_lead;
      r2        = norm_byte(req_tdata, sa, so);
      if (use2) begin
         sa = r2.after_sep;
         so = r2.space_owed;
      end
      step_sep  = sa;
      step_owed = so;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         new_byte[i] = SPACE_BYTE;
         new_pres[i] = 1'b1;
         new_fin[i]  = 1'b0;
      end
      n = 2'd0;
      if (use1 && r1.emit) begin
         if (r1.space) n = n + 2'd1;
         new_byte[n] = r1.data;
         n = n + 2'd1;
      end
      if (use2 && r2.emit) begin
         if (r2.space) n = n + 2'd1;
         new_byte[n] = r2.data;
         n = n + 2'd1;
      end
      if (req_tlast) begin
         if (n == 2'd0) begin
            // nothing emitted: bare end marker
            new_byte[0] = 8'h00;
            new_pres[0] = 1'b0;
            new_fin[0]  = 1'b1;
            n = 2'd1;
         end else begin
            new_fin[n - 2'd1] = 1'b1;
         end
      end
      new_count = n;
   end

   always_comb begin
      lead_held_in  = lead_held_ff;
      after_sep_in  = after_sep_ff;
      space_owed_in = space_owed_ff;
      count_in      = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_byte_in[i] = q_byte_ff[i];
         q_pres_in[i] = q_pres_ff[i];
         q_fin_in[i]  = q_fin_ff[i];
      end
      if (accept) begin
         lead_held_in  = req_tlast ? 1'b0 : step_lead;
         after_sep_in  = req_tlast ? 1'b1 : step_sep;
         space_owed_in = req_tlast ? 1'b0 : step_owed;
         count_in      = new_count;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_byte_in[i] = new_byte[i];
            q_pres_in[i] = new_pres[i];
            q_fin_in[i]  = new_fin[i];
         end
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_byte_in[i] = q_byte_ff[i + 1];
            q_pres_in[i] = q_pres_ff[i + 1];
            q_fin_in[i]  = q_fin_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_held_ff  <= 1'b0;
         after_sep_ff  <= 1'b1;
         space_owed_ff <= 1'b0;
         count_ff      <= 2'd0;
      end else begin
         lead_held_ff  <= lead_held_in;
         after_sep_ff  <= after_sep_in;
         space_owed_ff <= space_owed_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_byte_ff <= q_byte_in;
      q_pres_ff <= q_pres_in;
      q_fin_ff  <= q_fin_in;
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3 || !req_tready)
      else $error("result register overfilled or input taken while full");

   a_bare_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("bare end marker without final flag");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=>
         !lead_held_ff && after_sep_ff && !space_owed_ff)
      else $error("string state not back at start after end beat");

   a_end_gives_final: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("end beat produced no result");
`endif

endmodule
`default_nettype wire
